@@ design/gpd_pkg.sv @@
// ----------------------------------------------------------------------------
// gpd_pkg
// Shared types and constants for the gyro pointer delta block.
// ----------------------------------------------------------------------------
package gpd_pkg;

  // Samples taken for the bias estimate after reset
  localparam int CAL_SAMPLES = 40;
  localparam int CAL_W       = $clog2(CAL_SAMPLES + 1);

  // Field and state widths
  localparam int RATE_W     = 16;
  localparam int SUM_W      = 22;
  localparam int BIAS_W     = 24;
  localparam int GAIN_W     = 16;
  localparam int DZONE_W    = 15;
  localparam int MAXD_W     = 7;
  localparam int MOVE_W     = 8;
  localparam int FRAC_W     = 8;
  localparam int OUT_FRAC_W = 16;

  // Scaling datapath: Q.8 difference times unsigned Q8.8 gain
  localparam int DIFF_W = BIAS_W + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;

  // Bias division by CAL_SAMPLES through a reciprocal multiply
  localparam int DIV_IN_W  = SUM_W + FRAC_W;
  localparam int DIV_SHIFT = 32;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int DIV_PW    = DIV_IN_W + RECIP_W;
  localparam int FIX_W     = DIV_IN_W + CAL_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'((64'd1 << DIV_SHIFT) / CAL_SAMPLES);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA = 2'd2;

  localparam logic [GAIN_W-1:0]  GAIN_RST      = GAIN_W'(256);
  localparam logic [DZONE_W-1:0] DEADZONE_RST  = DZONE_W'(128);
  localparam logic [MAXD_W-1:0]  MAX_DELTA_RST = MAXD_W'(127);

  typedef struct packed {
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic                     read_ok;
    logic                     host_connected;
  } gpd_in_t;

  typedef struct packed {
    logic signed [MOVE_W-1:0] move_x;
    logic signed [MOVE_W-1:0] move_y;
  } gpd_out_t;

  // One scaled axis: the delta and whether the pre-truncation value moved
  typedef struct packed {
    logic                     nonzero;
    logic signed [MOVE_W-1:0] move;
  } gpd_axis_t;

  // Calibration status towards the top level
  typedef struct packed {
    logic busy;
    logic calibrating;
  } gpd_cal_stat_t;

endpackage

@@ design/gpd_calib.sv @@
// ----------------------------------------------------------------------------
// gpd_calib
// Sums calibration samples per axis and divides by the sample count to give
// Q.8 biases, truncated toward zero.
// ----------------------------------------------------------------------------
module gpd_calib (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  gpd_pkg::gpd_in_t                   item_i,
  output gpd_pkg::gpd_cal_stat_t             stat_o,
  output logic signed [gpd_pkg::BIAS_W-1:0]  bias_x_o,
  output logic signed [gpd_pkg::BIAS_W-1:0]  bias_y_o
);
  import gpd_pkg::*;

  typedef enum logic [1:0] {
    CAL_RUN,
    CAL_DIV,
    CAL_FIX,
    CAL_DONE
  } cal_state_e;

  cal_state_e                cal_state_q;
  logic [CAL_W-1:0]          cal_count_q;
  logic signed [SUM_W-1:0]   sum_q   [2];
  logic signed [SUM_W-1:0]   sum_d   [2];
  logic signed [BIAS_W-1:0]  bias_q  [2];
  logic signed [BIAS_W-1:0]  bias_d  [2];
  logic [DIV_IN_W-1:0]       dividend_q [2];
  logic [DIV_IN_W-1:0]       dividend_d [2];
  logic [DIV_IN_W-1:0]       qest_q  [2];
  logic [DIV_IN_W-1:0]       qest_d  [2];
  logic                      neg_q   [2];
  logic                      neg_d   [2];
  logic signed [RATE_W-1:0]  rate    [2];

  assign rate[0] = item_i.rate_x;
  assign rate[1] = item_i.rate_y;

  always_comb begin
    logic [SUM_W-1:0]  mag;
    logic [DIV_PW-1:0] prod;
    logic [FIX_W-1:0]  rem;
    logic [DIV_IN_W-1:0] quot;
    for (int a = 0; a < 2; a++) begin
      sum_d[a] = sum_q[a] + SUM_W'(rate[a]);

      // Divide stage: estimate from the reciprocal, may be one short
      neg_d[a]      = sum_q[a][SUM_W-1];
      mag           = neg_d[a] ? SUM_W'(-sum_q[a]) : SUM_W'(sum_q[a]);
      dividend_d[a] = {mag, {FRAC_W{1'b0}}};
      prod          = DIV_PW'(dividend_d[a]) * DIV_PW'(DIV_RECIP);
      qest_d[a]     = prod[DIV_SHIFT +: DIV_IN_W];

      // Fix stage: add one where the remainder still covers the divisor
      rem  = FIX_W'(dividend_q[a]) - FIX_W'(qest_q[a]) * FIX_W'(CAL_SAMPLES);
      quot = qest_q[a] + DIV_IN_W'(rem >= FIX_W'(CAL_SAMPLES));
      bias_d[a] = neg_q[a] ? -BIAS_W'(quot) : BIAS_W'(quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_state_q <= CAL_RUN;
      cal_count_q <= '0;
      for (int a = 0; a < 2; a++) begin
        sum_q[a]  <= '0;
        bias_q[a] <= '0;
      end
    end else begin
      case (cal_state_q)
        CAL_RUN: begin
          if (accept_i) begin
            cal_count_q <= cal_count_q + CAL_W'(1);
            if (item_i.read_ok) begin
              sum_q[0] <= sum_d[0];
              sum_q[1] <= sum_d[1];
            end
            if (cal_count_q == CAL_W'(CAL_SAMPLES - 1)) begin
              cal_state_q <= CAL_DIV;
            end
          end
        end
        CAL_DIV: cal_state_q <= CAL_FIX;
        CAL_FIX: begin
          bias_q[0]   <= bias_d[0];
          bias_q[1]   <= bias_d[1];
          cal_state_q <= CAL_DONE;
        end
        CAL_DONE: cal_state_q <= CAL_DONE;
        default:  cal_state_q <= CAL_RUN;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cal_state_q == CAL_DIV) begin
      for (int a = 0; a < 2; a++) begin
        dividend_q[a] <= dividend_d[a];
        qest_q[a]     <= qest_d[a];
        neg_q[a]      <= neg_d[a];
      end
    end
  end

  assign stat_o   = '{busy:        (cal_state_q == CAL_DIV) || (cal_state_q == CAL_FIX),
                      calibrating: (cal_state_q == CAL_RUN)};
  assign bias_x_o = bias_q[0];
  assign bias_y_o = bias_q[1];

endmodule

@@ design/gpd_axis.sv @@
// ----------------------------------------------------------------------------
// gpd_axis
// Scales one axis: bias removal, gain, deadzone and saturation.
// ----------------------------------------------------------------------------
module gpd_axis (
  input  logic signed [gpd_pkg::RATE_W-1:0] rate_i,
  input  logic signed [gpd_pkg::BIAS_W-1:0] bias_i,
  input  logic [gpd_pkg::GAIN_W-1:0]        gain_i,
  input  logic [gpd_pkg::DZONE_W-1:0]       deadzone_i,
  input  logic [gpd_pkg::MAXD_W-1:0]        max_delta_i,
  output gpd_pkg::gpd_axis_t                axis_o
);
  import gpd_pkg::*;

  logic signed [BIAS_W-1:0] rate_q8;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        mag;
  logic                     neg;
  logic                     dead;
  logic                     sat;
  logic [MAXD_W-1:0]        val;
  logic signed [MOVE_W-1:0] move_abs;

  assign rate_q8 = {rate_i, {FRAC_W{1'b0}}};
  assign diff    = DIFF_W'(rate_q8) - DIFF_W'(bias_i);
  assign prod    = PROD_W'(diff) * PROD_W'($signed({1'b0, gain_i}));
  assign neg     = prod[PROD_W-1];
  assign mag     = neg ? PROD_W'(-prod) : PROD_W'(prod);

  assign dead = mag < PROD_W'({deadzone_i, {FRAC_W{1'b0}}});
  assign sat  = mag > PROD_W'({max_delta_i, {OUT_FRAC_W{1'b0}}});

  // Below the limit the integer part fits the limit's width
  assign val      = sat ? max_delta_i : mag[OUT_FRAC_W +: MAXD_W];
  assign move_abs = $signed({1'b0, val});

  assign axis_o = '{nonzero: !dead && (mag != '0),
                    move:    dead ? '0 : (neg ? -move_abs : move_abs)};

endmodule

@@ design/gyro_pointer_delta.sv @@
// ----------------------------------------------------------------------------
// gyro_pointer_delta
// Turns gyro rate samples into pointer moves after a bias calibration.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  in      | sink      | in_valid_i / in_stall_o | gpd_in_t  (rates, flags)
//  out     | source    | out_valid_o/out_stall_i | gpd_out_t (move_x/y)
//  cfg     | sink      | cfg_we_i                | gain, deadzone, max_delta
//
// One item a cycle unless the output or bias divide stalls: an item is
// registered, scaled in one pass through two multipliers and registered
// again in the result register. After the last calibration item the input
// stalls through the divide and fix states while the bias divide finishes.
// Reset restores the register defaults and restarts calibration. A stalled
// result holds while one more item waits in the input register.
// ----------------------------------------------------------------------------
module gyro_pointer_delta (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [gpd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [gpd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  gpd_pkg::gpd_in_t                     in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output gpd_pkg::gpd_out_t                    out_data_o
);
  import gpd_pkg::*;

  logic [GAIN_W-1:0]        gain_q;
  logic [DZONE_W-1:0]       deadzone_q;
  logic [MAXD_W-1:0]        max_delta_q;
  gpd_cal_stat_t            cal_stat;
  logic signed [BIAS_W-1:0] bias_x;
  logic signed [BIAS_W-1:0] bias_y;
  logic                     in_accept;
  logic                     advance;
  logic                     pipe_en;
  logic                     pipe_valid_q;
  logic                     pipe_valid_d;
  gpd_in_t                  pipe_q;
  logic                     out_valid_q;
  gpd_out_t                 out_q;
  gpd_axis_t                axis_x;
  gpd_axis_t                axis_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= GAIN_RST;
      deadzone_q  <= DEADZONE_RST;
      max_delta_q <= MAX_DELTA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN:      gain_q      <= cfg_wdata_i[GAIN_W-1:0];
        CFG_DEADZONE:  deadzone_q  <= cfg_wdata_i[DZONE_W-1:0];
        CFG_MAX_DELTA: max_delta_q <= cfg_wdata_i[MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  // Result register frees up when empty or taken this cycle
  assign advance    = !out_valid_q || !out_stall_i;
  assign pipe_en    = !pipe_valid_q || advance;
  assign in_stall_o = cal_stat.busy || !pipe_en;
  assign in_accept  = in_valid_i && !in_stall_o;

  gpd_calib u_calib (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .stat_o   (cal_stat),
    .bias_x_o (bias_x),
    .bias_y_o (bias_y)
  );

  // Drop calibration items and ticks with a failed read or no host
  assign pipe_valid_d = in_accept && !cal_stat.calibrating &&
                        in_data_i.read_ok && in_data_i.host_connected;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pipe_en) begin
        pipe_valid_q <= pipe_valid_d;
      end
      if (advance) begin
        out_valid_q <= pipe_valid_q && (axis_x.nonzero || axis_y.nonzero);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pipe_q <= in_data_i;
    end
    if (advance) begin
      out_q.move_x <= axis_x.move;
      out_q.move_y <= axis_y.move;
    end
  end

  // Horizontal motion follows the y rate, vertical the x rate
  gpd_axis u_axis_x (
    .rate_i      (pipe_q.rate_y),
    .bias_i      (bias_y),
    .gain_i      (gain_q),
    .deadzone_i  (deadzone_q),
    .max_delta_i (max_delta_q),
    .axis_o      (axis_x)
  );

  gpd_axis u_axis_y (
    .rate_i      (pipe_q.rate_x),
    .bias_i      (bias_x),
    .gain_i      (gain_q),
    .deadzone_i  (deadzone_q),
    .max_delta_i (max_delta_q),
    .axis_o      (axis_y)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
